/* sv/gltd_pkg.sv */
// Shared types, constants and register indexes for the telegram deframer.
`default_nettype none
package gltd_pkg;
	localparam int BUF_BYTES_DEF = 64;
	localparam int CAPTURE_AT    = 4;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 1;

	localparam logic [15:0] GAP_RESET    = 16'd15;
	localparam logic [1:0]  LENIDX_RESET = 2'd3;
	localparam logic [7:0]  LEN_UNKNOWN  = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_MS       = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_INDEX = 1'd1;

	localparam logic KIND_LENGTH = 1'b0;
	localparam logic KIND_GAP    = 1'b1;

	typedef logic [7:0]  byte_t;
	typedef logic [31:0] ms_t;
endpackage
`default_nettype wire

/* sv/gltd_ifs.sv */
// Valid/ready channel interfaces for received bytes and emitted frame bytes.
`default_nettype none
interface gltd_in_if;
	import gltd_pkg::*;
	logic  valid;
	logic  ready;
	byte_t rx_byte;
	ms_t   time_ms;
	modport source (output valid, output rx_byte, output time_ms, input ready);
	modport sink (input valid, input rx_byte, input time_ms, output ready);
endinterface

interface gltd_out_if;
	import gltd_pkg::*;
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  frame_kind;
	logic  last_of_frame;
	ms_t   dropped_total;
	modport source (output valid, output data_byte, output frame_kind,
		output last_of_frame, output dropped_total, input ready);
	modport sink (input valid, input data_byte, input frame_kind,
		input last_of_frame, input dropped_total, output ready);
endinterface
`default_nettype wire

/* sv/gap_and_length_telegram_deframer_top.sv */
// Telegram deframer top: idle-gap and length-prefixed splitting of a byte stream.
//
// in_ch carries one received byte with its millisecond time stamp per beat;
// out_ch carries one emitted frame byte per beat, with the frame kind
// (length-complete or gap-cut), a last-byte flag and the running drop count.
// Bytes are held in a BUF_BYTES ring RAM. A small sequencer runs each input
// beat through gap test, store, length test and, when a frame is released,
// a read-out loop that reads one byte from the RAM per pass.
// An input beat with no release passes the gap, store and test states (and
// the capture state when it captures the length byte) before in_ch is ready
// again. A release runs one RAM read and one output-register load per byte.
// The output register frees the sequencer to take the next input beat
// while the final byte still waits; a stalled out_ch holds the read-out
// loop at its RAM read step, nothing is lost.
// Reset clears held count, ring position, length and time status, the
// drop count and the registers (gap_ms 15, length_index 3). The RAM needs
// no clearing: only held bytes are ever read. cfg_we/cfg_index/cfg_data write
// a register; the user writes only while idle, the block does not enforce it.
`default_nettype none
module gap_and_length_telegram_deframer_top #(
	parameter int BUF_BYTES = gltd_pkg::BUF_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	gltd_in_if.sink                             in_ch,
	gltd_out_if.source                          out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [gltd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gltd_pkg::CFG_W-1:0]     cfg_data
);
	import gltd_pkg::*;

	localparam int IDX_W = $clog2(BUF_BYTES);
	localparam int CNT_W = $clog2(BUF_BYTES + 1);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_GAP     = 3'd1;
	localparam logic [2:0] S_STORE   = 3'd2;
	localparam logic [2:0] S_TEST    = 3'd3;
	localparam logic [2:0] S_CAP     = 3'd4;
	localparam logic [2:0] S_EMIT_RD = 3'd5;
	localparam logic [2:0] S_EMIT_LD = 3'd6;

	logic [2:0]       state_q;
	logic [15:0]      gap_ms_q;
	logic [1:0]       len_idx_q;
	byte_t            byte_q;
	ms_t              time_q;
	ms_t              prev_q;
	logic             time_known_q;
	logic [7:0]       len_q;
	logic             len_known_q;
	logic [IDX_W-1:0] rp_q;
	logic [CNT_W-1:0] held_q;
	ms_t              ovf_q;
	logic [IDX_W-1:0] ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic             kind_q;
	logic             ret_store_q;

	logic             out_valid_q;
	byte_t            out_data_q;
	logic             out_kind_q;
	logic             out_last_q;
	ms_t              out_drop_q;

	// shared ring adder
	logic [IDX_W-1:0] ra_base;
	logic [CNT_W-1:0] ra_off;
	logic [IDX_W-1:0] ra_sum;

	gltd_ring_add #(.DEPTH(BUF_BYTES)) u_ring_add (
		.base(ra_base),
		.off (ra_off),
		.sum (ra_sum)
	);

	always_comb begin
		case (state_q)
			S_TEST: begin
				ra_base = rp_q;
				ra_off  = CNT_W'(len_idx_q);
			end
			S_EMIT_LD: begin
				ra_base = ptr_q;
				ra_off  = CNT_W'(1);
			end
			default: begin
				ra_base = rp_q;
				ra_off  = held_q;
			end
		endcase
	end

	// frame store
	logic             ram_we;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	byte_t            ram_rdata;
	logic             out_free;

	assign out_free = !out_valid_q || out_ch.ready;
	assign ram_we   = (state_q == S_STORE) && (held_q < CNT_W'(BUF_BYTES));
	assign ram_re   = (state_q == S_TEST) || ((state_q == S_EMIT_RD) && out_free);
	assign ram_raddr = (state_q == S_TEST) ? ra_sum : ptr_q;

	gltd_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ra_sum),
		.wdata(byte_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// gap test and length compares
	ms_t            idle_ms;
	logic           gap_hit;
	logic [CMP_W-1:0] held_x;
	logic [CMP_W-1:0] len_x;
	logic           emit_last;

	assign idle_ms   = time_q - prev_q;
	assign gap_hit   = time_known_q && (idle_ms > {16'd0, gap_ms_q});
	assign held_x    = CMP_W'(held_q);
	assign len_x     = CMP_W'(len_q);
	assign emit_last = (cnt_q + CNT_W'(1)) == n_q;

	assign in_ch.ready          = (state_q == S_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.data_byte     = out_data_q;
	assign out_ch.frame_kind    = out_kind_q;
	assign out_ch.last_of_frame = out_last_q;
	assign out_ch.dropped_total = out_drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			gap_ms_q     <= GAP_RESET;
			len_idx_q    <= LENIDX_RESET;
			prev_q       <= '0;
			time_known_q <= 1'b0;
			len_q        <= LEN_UNKNOWN;
			len_known_q  <= 1'b0;
			rp_q         <= '0;
			held_q       <= '0;
			ovf_q        <= '0;
			cnt_q        <= '0;
			n_q          <= '0;
			ptr_q        <= '0;
			kind_q       <= KIND_LENGTH;
			ret_store_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_GAP_MS) begin
					gap_ms_q <= cfg_data;
				end else if (cfg_index == REG_LENGTH_INDEX) begin
					len_idx_q <= cfg_data[1:0];
				end
			end

			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						state_q <= S_GAP;
					end
				end
				S_GAP: begin
					prev_q       <= time_q;
					time_known_q <= 1'b1;
					state_q      <= S_STORE;
					if (gap_hit) begin
						len_known_q <= 1'b0;
						len_q       <= LEN_UNKNOWN;
						if (held_q != '0) begin
							ptr_q       <= rp_q;
							cnt_q       <= '0;
							n_q         <= held_q;
							kind_q      <= KIND_GAP;
							ret_store_q <= 1'b1;
							state_q     <= S_EMIT_RD;
						end
					end
				end
				S_STORE: begin
					if (held_q < CNT_W'(BUF_BYTES)) begin
						held_q <= held_q + CNT_W'(1);
					end
					state_q <= S_TEST;
				end
				S_TEST: begin
					state_q <= S_IDLE;
					if (!len_known_q) begin
						if (held_q >= CNT_W'(CAPTURE_AT)) begin
							state_q <= S_CAP;
						end
					end else if (held_x >= len_x) begin
						// complete, or longer than the length: emit the front part
						len_known_q <= 1'b0;
						len_q       <= LEN_UNKNOWN;
						if (len_q != 8'd0) begin
							ptr_q       <= rp_q;
							cnt_q       <= '0;
							n_q         <= (held_x == len_x) ? held_q : CNT_W'(len_q);
							kind_q      <= KIND_LENGTH;
							ret_store_q <= 1'b0;
							state_q     <= S_EMIT_RD;
						end
					end else if (held_q == CNT_W'(BUF_BYTES)) begin
						held_q <= '0;
						rp_q   <= '0;
						ovf_q  <= ovf_q + 32'(BUF_BYTES);
					end
				end
				S_CAP: begin
					len_q       <= ram_rdata;
					len_known_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_EMIT_RD: begin
					if (out_free) begin
						state_q <= S_EMIT_LD;
					end
				end
				S_EMIT_LD: begin
					out_valid_q <= 1'b1;
					ptr_q       <= ra_sum;
					cnt_q       <= cnt_q + CNT_W'(1);
					state_q     <= S_EMIT_RD;
					if (emit_last) begin
						held_q  <= held_q - n_q;
						rp_q    <= (held_q == n_q) ? '0 : ra_sum;
						state_q <= ret_store_q ? S_STORE : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// input and output payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_q <= in_ch.rx_byte;
			time_q <= in_ch.time_ms;
		end
		if (state_q == S_EMIT_LD) begin
			out_data_q <= ram_rdata;
			out_kind_q <= kind_q;
			out_last_q <= emit_last;
			out_drop_q <= ovf_q;
		end
	end
endmodule
`default_nettype wire

/* sv/gltd_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module gltd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

/* sv/gltd_ring_add.sv */
// Ring index adder: (base + off) modulo DEPTH, with base < DEPTH and off <= DEPTH.
`default_nettype none
module gltd_ring_add #(
	parameter int DEPTH = 64
) (
	input  wire logic [$clog2(DEPTH)-1:0]   base,
	input  wire logic [$clog2(DEPTH+1)-1:0] off,
	output logic      [$clog2(DEPTH)-1:0]   sum
);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W:0] raw;
	logic [CNT_W:0] wrapped;

	always_comb begin
		raw = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (raw >= (CNT_W+1)'(DEPTH)) begin
			wrapped = raw - (CNT_W+1)'(DEPTH);
		end else begin
			wrapped = raw;
		end
		sum = wrapped[IDX_W-1:0];
	end
endmodule
`default_nettype wire

/* tb/gltd_telegram_monitor.sv */
// Channel monitor for the telegram deframer: predicts emitted frame bytes and checks them.
`default_nettype none
module gltd_telegram_monitor #(
	parameter int DEPTH = gltd_pkg::BUF_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	gltd_in_if                                  in_ch,
	gltd_out_if                                 out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [gltd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gltd_pkg::CFG_W-1:0]     cfg_data,
	output int                                  mismatches,
	output int                                  bytes_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import gltd_pkg::*;

	typedef struct packed {
		byte_t data;
		logic  kind;
		logic  last;
		ms_t   dropped;
	} frame_byte_t;

	frame_byte_t owed[$];
	byte_t       ring[DEPTH];
	int          head;
	int          held;
	byte_t       tel_len;
	bit          tel_len_ok;
	ms_t         prev_ms;
	bit          prev_ok;
	ms_t         drop_sum;
	logic [15:0] gap_lim;
	logic [1:0]  len_pos;
	int          errs = 0;

	assign mismatches = errs;

	function automatic int slot(int off);
		return (head + off) % DEPTH;
	endfunction

	// Queue the oldest n held bytes as one frame and drop them from the ring.
	function automatic void release_front(int n, logic kind);
		frame_byte_t fb;
		int i;
		for (i = 0; i < n; i++) begin
			fb.data    = ring[slot(i)];
			fb.kind    = kind;
			fb.last    = (i == n - 1);
			fb.dropped = drop_sum;
			owed.push_back(fb);
		end
		head = slot(n);
		held -= n;
		if (held == 0)
			head = 0;
	endfunction

	function automatic void take_byte(byte_t b, ms_t t);
		// idle time is modular, so a wrapped stamp still measures correctly
		if (prev_ok && ms_t'(t - prev_ms) > ms_t'(gap_lim)) begin
			if (held > 0)
				release_front(held, KIND_GAP);
			tel_len_ok = 1'b0;
			tel_len    = LEN_UNKNOWN;
		end
		prev_ms = t;
		prev_ok = 1'b1;

		// a full ring silently discards the new byte
		if (held < DEPTH) begin
			ring[slot(held)] = b;
			held++;
		end

		// capture step makes no other test
		if (!tel_len_ok) begin
			if (held >= CAPTURE_AT) begin
				tel_len    = ring[slot(int'(len_pos))];
				tel_len_ok = 1'b1;
			end
			return;
		end

		if (held == int'(tel_len)) begin
			release_front(held, KIND_LENGTH);
			tel_len_ok = 1'b0;
			tel_len    = LEN_UNKNOWN;
		end else if (held > int'(tel_len)) begin
			release_front(int'(tel_len), KIND_LENGTH);
			tel_len_ok = 1'b0;
			tel_len    = LEN_UNKNOWN;
		end else if (held == DEPTH) begin
			// overflow flush keeps the length
			held     = 0;
			head     = 0;
			drop_sum += ms_t'(DEPTH);
		end
	endfunction

	function automatic void check_beat();
		frame_byte_t want;
		if (owed.size() == 0) begin
			errs++;
			$error("data_byte %02h arrived with no frame byte expected", out_ch.data_byte);
			return;
		end
		want = owed.pop_front();
		if (out_ch.data_byte !== want.data) begin
			errs++;
			$error("data_byte: expected %02h, got %02h", want.data, out_ch.data_byte);
		end
		if (out_ch.frame_kind !== want.kind) begin
			errs++;
			$error("frame_kind: expected %0b, got %0b", want.kind, out_ch.frame_kind);
		end
		if (out_ch.last_of_frame !== want.last) begin
			errs++;
			$error("last_of_frame: expected %0b, got %0b", want.last, out_ch.last_of_frame);
		end
		if (out_ch.dropped_total !== want.dropped) begin
			errs++;
			$error("dropped_total: expected %0d, got %0d", want.dropped, out_ch.dropped_total);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed.delete();
			head       = 0;
			held       = 0;
			tel_len    = LEN_UNKNOWN;
			tel_len_ok = 1'b0;
			prev_ms    = '0;
			prev_ok    = 1'b0;
			drop_sum   = '0;
			gap_lim    = GAP_RESET;
			len_pos    = LENIDX_RESET;
			bytes_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAP_MS:       gap_lim = cfg_data[15:0];
					REG_LENGTH_INDEX: len_pos = cfg_data[1:0];
					default: ;
				endcase
			end
			// output first: a beat leaving now belongs to an earlier input
			if (out_ch.valid && out_ch.ready)
				check_beat();
			if (in_ch.valid && in_ch.ready)
				take_byte(in_ch.rx_byte, in_ch.time_ms);
			bytes_due <= owed.size();
		end
	end
endmodule
`default_nettype wire

/* tb/gap_and_length_telegram_deframer_top_tb.sv */
// Testbench top for the telegram deframer: clock, reset, stimulus and verdict.
`default_nettype none
module gap_and_length_telegram_deframer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gltd_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 16;
	localparam int TAIL_CYCLES  = 40;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   mismatches;
	int                   bytes_due;
	int                   cycles = 0;
	int                   sink_hold = 0;
	bit                   in_gaps = 1'b1;
	bit                   out_stalls = 1'b1;
	ms_t                  now_ms;
	logic [15:0]          gap_set;
	logic [1:0]           idx_set;
	int                   sent = 0;
	int                   mark;

	gltd_in_if  in_ch();
	gltd_out_if out_ch();

	gap_and_length_telegram_deframer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gltd_telegram_monitor frame_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.bytes_due  (bytes_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// sink side: random stall bursts between ready runs
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			sink_hold    <= 0;
		end else if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
		end else if (out_stalls && $urandom_range(0, 3) == 0) begin
			out_ch.ready <= 1'b0;
			sink_hold    <= $urandom_range(0, 12);
		end else begin
			out_ch.ready <= 1'b1;
			sink_hold    <= $urandom_range(0, 20);
		end
	end

	function automatic ms_t quiet_step();
		if ($urandom_range(0, 3) == 0)
			return ms_t'(gap_set);
		return ms_t'($urandom_range(0, gap_set));
	endfunction

	function automatic ms_t break_step();
		ms_t r;
		case ($urandom_range(0, 2))
			0: r = ms_t'(gap_set) + 1;
			1: r = ms_t'(gap_set) + 1 + $urandom_range(0, 5000);
			default: begin
				r = $urandom();
				if (r <= ms_t'(gap_set))
					r = ms_t'(gap_set) + 1;
			end
		endcase
		return r;
	endfunction

	// one beat on in_ch; valid stays high afterwards until the next call or a drain
	task automatic put_byte(input byte_t b, input ms_t step);
		now_ms += step;
		sent++;
		if (in_gaps && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.rx_byte <= b;
		in_ch.time_ms <= now_ms;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	// telegram with len_val at the length position, random payload elsewhere
	task automatic send_telegram(input int len_val, input int count, input bit fresh);
		int    i;
		byte_t b;
		ms_t   step;
		for (i = 0; i < count; i++) begin
			b    = (i == int'(idx_set)) ? byte_t'(len_val) : byte_t'($urandom());
			step = (i == 0 && fresh) ? break_step() : quiet_step();
			put_byte(b, step);
		end
	endtask

	task automatic run_scenario();
		int pick;
		int n;
		int i;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(4, 24);
			send_telegram(n, n, $urandom_range(0, 3) != 0);
		end else if (pick < 62) begin
			// length below the capture point: excess split on the next beat
			send_telegram($urandom_range(0, 3), $urandom_range(5, 9), 1'b1);
		end else if (pick < 78) begin
			send_telegram($urandom_range(0, 255), $urandom_range(1, 10), 1'b1);
		end else if (pick < 97) begin
			n = $urandom_range(1, 8);
			for (i = 0; i < n; i++)
				put_byte(byte_t'($urandom()),
					($urandom_range(0, 2) == 0) ? break_step() : quiet_step());
		end else begin
			send_telegram($urandom_range(65, 255), $urandom_range(65, 72), 1'b1);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (bytes_due != 0)
			@(posedge clk);
		// a beat with no release may still be in the sequencer
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] gap, input logic [1:0] idx);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_GAP_MS;
		cfg_data  <= gap;
		@(posedge clk);
		cfg_index <= REG_LENGTH_INDEX;
		cfg_data  <= CFG_W'(idx);
		@(posedge clk);
		cfg_we  <= 1'b0;
		gap_set = gap;
		idx_set = idx;
	endtask

	initial begin
		in_ch.valid   = 1'b0;
		in_ch.rx_byte = '0;
		in_ch.time_ms = '0;
		out_ch.ready  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_GAP_MS;
		cfg_data      = '0;
		arst_n        = 1'b0;
		gap_set       = GAP_RESET;
		idx_set       = LENIDX_RESET;
		now_ms        = 32'hFFFF_FFF5;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// first byte ever, stamps wrapping through zero, complete 6-byte telegram
		put_byte(8'h00, 3);
		put_byte(8'hFF, 3);
		put_byte(8'h80, 3);
		put_byte(8'd6, 3);
		put_byte(8'h55, 3);
		put_byte(8'hAA, 3);
		// gap with nothing held, then exactly gap_ms (no cut), then a cut of 3
		put_byte(8'h01, 16);
		put_byte(8'h02, 15);
		put_byte(8'h03, 0);
		put_byte(8'h7F, 16);
		// length zero: empty frame, bytes kept, length recaptured as zero
		put_byte(8'h11, 1);
		put_byte(8'h22, 1);
		put_byte(8'h00, 1);
		put_byte(8'h33, 1);
		put_byte(8'h44, 1);
		put_byte(8'h09, 32'h8000_0000);
		// length 2: excess split, then a recaptured length of 4 from the remainder
		put_byte(8'h08, 2);
		put_byte(8'h07, 2);
		put_byte(8'h02, 2);
		put_byte(8'hF0, 1);
		put_byte(8'h04, 1);
		put_byte(8'hC3, 5);
		put_byte(8'h5A, 32'hFFFF_0000);

		// zero length kept at the front fills the ring, extra bytes are discarded
		set_regs(16'd0, 2'd0);
		send_telegram(0, 70, 1'b1);
		mark = sent + 25;
		while (sent < mark)
			run_scenario();

		// length 255 never completes: overflow flush with the length kept
		set_regs(16'hFFFF, 2'd3);
		send_telegram(255, 69, 1'b1);
		mark = sent + 25;
		while (sent < mark)
			run_scenario();

		set_regs(16'($urandom_range(1, 300)), 2'd1);
		send_telegram(64, 64, 1'b1);
		mark = sent + 25;
		while (sent < mark)
			run_scenario();

		in_gaps    = 1'b0;
		out_stalls = 1'b0;
		set_regs(16'd15, 2'd2);
		mark = sent + 25;
		while (sent < mark)
			run_scenario();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && bytes_due == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
sv/gltd_pkg.sv
sv/gltd_ifs.sv
sv/gltd_ram.sv
sv/gltd_ring_add.sv
sv/gap_and_length_telegram_deframer_top.sv
tb/gltd_telegram_monitor.sv
tb/gap_and_length_telegram_deframer_top_tb.sv
